// ===== hdl/plbt_pkg.sv =====
package plbt_pkg;

  // Number of price levels kept for each side of the book.
  localparam int LEVELS_PER_SIDE = 16;

  // Width of a level index inside one side's row of cells.
  localparam int IDX_W = (LEVELS_PER_SIDE > 1) ? $clog2(LEVELS_PER_SIDE) : 1;

  localparam int PRICE_W  = 16;
  localparam int OQTY_W   = 16;
  localparam int COUNT_W  = 16;
  localparam int TOTAL_W  = 32;
  localparam int RANK_W   = 4;

  // Order side as carried in the opcode field.
  localparam logic OPC_BUY  = 1'b0;
  localparam logic OPC_SELL = 1'b1;

  // One price level as held by a cell.
  typedef struct packed {
    logic               valid;
    logic [PRICE_W-1:0] price;
    logic [COUNT_W-1:0] orders;
    logic [TOTAL_W-1:0] total;
  } entry_t;

  // Request broadcast from the top level to every cell of one row.
  typedef struct packed {
    logic               sell;
    logic [PRICE_W-1:0] price;
    logic [OQTY_W-1:0]  qty;
    logic               cmp_en;
    logic               upd_en;
  } cmd_t;

  // Update control decided by a row for all of its cells.
  typedef struct packed {
    logic absorb;
    logic insert;
  } cell_ctl_t;

  // Result of one request as produced by a row.
  typedef struct packed {
    logic [RANK_W-1:0]  rank;
    logic [COUNT_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    logic [PRICE_W-1:0] price;
    logic               new_level;
    logic               full;
  } result_t;

endpackage

// ===== hdl/order_book_price_level_table.sv =====
// Channel   Direction  Payload
// s_axis    in         tdata: order_quantity[15:0], order_price[31:16]; tuser: opcode
// m_axis    out        tdata: level_rank[3:0], level_order_count[19:4],
//                      level_total_quantity[51:20], level_price[67:52], zero pad to 72;
//                      tuser: new_level[0], book_full[1]
//
// A request is captured at its accepting edge, compared in every cell of the side's row
// in the next cycle, and applied in the update state that follows (join, or a one-step shift
// down the chain for an insert), which also loads the output register with the result.
// The next request is accepted only once the update is done, so requests never overlap.
// A result waiting on m_axis holds the update step; reset is synchronous and empties
// both sides of the book.
module order_book_price_level_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // order_quantity, order_price
  input  logic        s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // level_rank, level_order_count,
                                      // level_total_quantity, level_price, pad
  output logic [1:0]  m_axis_tuser    // new_level, book_full
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  logic                          sell;
  logic [plbt_pkg::OQTY_W-1:0]   qty;
  logic [plbt_pkg::PRICE_W-1:0]  price;
  logic                          fire;
  plbt_pkg::cmd_t                buy_cmd;
  plbt_pkg::cmd_t                sell_cmd;
  plbt_pkg::result_t             buy_res;
  plbt_pkg::result_t             sell_res;
  plbt_pkg::result_t             res;

  assign s_axis_tready = (state == ST_IDLE);
  assign fire          = (state == ST_UPD) && (!m_axis_tvalid || m_axis_tready);

  // Request sequencing.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (s_axis_tvalid) state_next = ST_CMP;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  if (fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Capture the accepted request.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      sell  <= (s_axis_tuser == plbt_pkg::OPC_SELL);
      qty   <= s_axis_tdata[15:0];
      price <= s_axis_tdata[31:16];
    end
  end

  // Commands to the two rows; only the side of the request is enabled.
  always_comb begin
    buy_cmd.sell   = 1'b0;
    buy_cmd.price  = price;
    buy_cmd.qty    = qty;
    buy_cmd.cmp_en = (state == ST_CMP) && !sell;
    buy_cmd.upd_en = fire && !sell;
    sell_cmd       = buy_cmd;
    sell_cmd.sell  = 1'b1;
    sell_cmd.cmp_en = (state == ST_CMP) && sell;
    sell_cmd.upd_en = fire && sell;
  end

  plbt_row u_buy (
    .clk    (clk),
    .rst    (rst),
    .cmd    (buy_cmd),
    .result (buy_res)
  );

  plbt_row u_sell (
    .clk    (clk),
    .rst    (rst),
    .cmd    (sell_cmd),
    .result (sell_res)
  );

  assign res = sell ? sell_res : buy_res;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_axis_tdata <= {4'b0, res.price, res.total, res.count, res.rank};
      m_axis_tuser <= {res.full, res.new_level};
    end
  end

endmodule

// ===== hdl/plbt_cell.sv =====
module plbt_cell (
  input  logic               clk,
  input  logic               rst,
  input  plbt_pkg::cmd_t     cmd,
  input  plbt_pkg::cell_ctl_t ctl,
  input  logic               prev_go,
  input  plbt_pkg::entry_t   prev_entry,
  output plbt_pkg::entry_t   entry,
  output logic               go,
  output logic               match,
  output plbt_pkg::entry_t   absorbed
);

  plbt_pkg::entry_t entry_next;
  logic [plbt_pkg::TOTAL_W:0] sum;
  logic better;

  // The new price ranks ahead of this level when it is strictly better.
  assign better = cmd.sell ? (cmd.price < entry.price) : (cmd.price > entry.price);

  // Compare phase: remember whether the price matches or the insert point is here or above.
  always_ff @(posedge clk) begin
    if (rst) begin
      go    <= 1'b0;
      match <= 1'b0;
    end else if (cmd.cmp_en) begin
      match <= entry.valid && (cmd.price == entry.price);
      go    <= !entry.valid || better;
    end
  end

  // Level contents after the order joins it, with saturation.
  always_comb begin
    absorbed       = entry;
    sum            = {1'b0, entry.total} + {{(plbt_pkg::TOTAL_W + 1 - plbt_pkg::OQTY_W){1'b0}},
                                            cmd.qty};
    absorbed.total = sum[plbt_pkg::TOTAL_W] ? '1 : sum[plbt_pkg::TOTAL_W-1:0];
    if (entry.orders != '1) begin
      absorbed.orders = entry.orders + 1'b1;
    end
  end

  // Update phase: join, shift down from the neighbor, or take the new level.
  always_comb begin
    entry_next = entry;
    if (ctl.absorb && match) begin
      entry_next = absorbed;
    end else if (ctl.insert && go && prev_go) begin
      entry_next = prev_entry;
    end else if (ctl.insert && go) begin
      entry_next.valid  = 1'b1;
      entry_next.price  = cmd.price;
      entry_next.orders = plbt_pkg::COUNT_W'(1);
      entry_next.total  = {{(plbt_pkg::TOTAL_W - plbt_pkg::OQTY_W){1'b0}}, cmd.qty};
    end
  end

  // Level register; only the valid flag is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else if (cmd.upd_en) begin
      entry <= entry_next;
    end
  end

endmodule

// ===== hdl/plbt_row.sv =====
module plbt_row (
  input  logic                clk,
  input  logic                rst,
  input  plbt_pkg::cmd_t      cmd,
  output plbt_pkg::result_t   result
);

  localparam int N = plbt_pkg::LEVELS_PER_SIDE;

  plbt_pkg::entry_t  ent [N];
  plbt_pkg::entry_t  absorbed [N];
  logic [N-1:0]      go;
  logic [N-1:0]      match;
  logic [N-1:0]      first;
  logic              any_match;
  logic              full;
  plbt_pkg::cell_ctl_t ctl;
  logic [plbt_pkg::IDX_W-1:0] idx;
  logic [plbt_pkg::IDX_W+plbt_pkg::RANK_W-1:0] idx_wide;
  plbt_pkg::entry_t  hit;

  // Chain of cells, best price in cell zero; each cell hands its level to the next.
  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_head
      plbt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .ctl        (ctl),
        .prev_go    (1'b0),
        .prev_entry ('0),
        .entry      (ent[i]),
        .go         (go[i]),
        .match      (match[i]),
        .absorbed   (absorbed[i])
      );
    end else begin : g_body
      plbt_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .cmd        (cmd),
        .ctl        (ctl),
        .prev_go    (go[i-1]),
        .prev_entry (ent[i-1]),
        .entry      (ent[i]),
        .go         (go[i]),
        .match      (match[i]),
        .absorbed   (absorbed[i])
      );
    end
  end

  assign any_match  = |match;
  assign full       = ent[N-1].valid;
  assign first      = go & ~{go[N-2:0], 1'b0};
  assign ctl.absorb = cmd.upd_en && any_match;
  assign ctl.insert = cmd.upd_en && !any_match && !full;

  // One-hot to index for the matched level or the insert point, and the matched level.
  always_comb begin
    idx = '0;
    hit = '0;
    for (int i = 0; i < N; i++) begin
      if (any_match ? match[i] : first[i]) begin
        idx = idx | plbt_pkg::IDX_W'(i);
      end
      if (match[i]) begin
        hit = hit | absorbed[i];
      end
    end
  end

  assign idx_wide = {{plbt_pkg::RANK_W{1'b0}}, idx};

  // Result of the request: joined level, new level, or dropped on a full side.
  always_comb begin
    result = '0;
    if (any_match) begin
      result.rank  = idx_wide[plbt_pkg::RANK_W-1:0];
      result.count = hit.orders;
      result.total = hit.total;
      result.price = hit.price;
    end else if (full) begin
      result.full = 1'b1;
    end else begin
      result.rank      = idx_wide[plbt_pkg::RANK_W-1:0];
      result.count     = plbt_pkg::COUNT_W'(1);
      result.total     = {{(plbt_pkg::TOTAL_W - plbt_pkg::OQTY_W){1'b0}}, cmd.qty};
      result.price     = cmd.price;
      result.new_level = 1'b1;
    end
  end

endmodule

// ===== sim/order_book_price_level_table_tb.sv =====
module order_book_price_level_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // About 580 to 610 requests, stretched by random gaps on the input and back-pressure
  // on the output, finish well inside the limit, which leaves a wide margin.
  localparam int CYCLE_LIMIT = 100_000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_LIMIT = 50;
  localparam int JOIN_ORDERS = 100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;    // order_quantity[15:0], order_price[31:16]
  logic        s_axis_tuser = 1'b0;  // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;         // level_rank[3:0], level_order_count[19:4],
                                     // level_total_quantity[51:20], level_price[67:52]
  logic [1:0]  m_axis_tuser;         // new_level[0], book_full[1]

  // Shadow copy of both sides of the book, indexed by side then rank.
  logic [plbt_pkg::PRICE_W-1:0] book_price  [2][plbt_pkg::LEVELS_PER_SIDE];
  logic [plbt_pkg::COUNT_W-1:0] book_orders [2][plbt_pkg::LEVELS_PER_SIDE];
  logic [plbt_pkg::TOTAL_W-1:0] book_total  [2][plbt_pkg::LEVELS_PER_SIDE];
  int unsigned                  book_used   [2] = '{0, 0};

  plbt_pkg::result_t level_expect_q[$];
  plbt_pkg::result_t level_got;
  plbt_pkg::result_t level_want;
  int      error_count = 0;
  int      cycle_count = 0;
  bit      idle_en = 1'b1;

  order_book_price_level_table uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Free-running 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[order_book_price_level_table] ERROR");
      $finish;
    end
  end

  // Prints one line per mismatch up to a cap, and counts every one.
  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input longint unsigned got,
                             input longint unsigned want);
    if (got != want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Rank of the level holding this price on one side, or -1 if there is none.
  function automatic int level_of(input logic side,
                                  input logic [plbt_pkg::PRICE_W-1:0] price);
    int hit;
    hit = -1;
    for (int i = 0; i < book_used[side]; i++)
      if (hit < 0 && book_price[side][i] == price) hit = i;
    return hit;
  endfunction

  // Applies one order to the shadow book and returns the level it touched.
  function automatic plbt_pkg::result_t apply_order(
      input logic side, input logic [plbt_pkg::OQTY_W-1:0] qty,
      input logic [plbt_pkg::PRICE_W-1:0] price);
    plbt_pkg::result_t              r;
    int                             hit;
    int                             pos;
    int                             used;
    logic [plbt_pkg::TOTAL_W:0]     sum;
    logic [plbt_pkg::TOTAL_W-1:0]   qty_wide;
    r = '0;
    qty_wide = {{(plbt_pkg::TOTAL_W - plbt_pkg::OQTY_W){1'b0}}, qty};
    used = int'(book_used[side]);
    hit = level_of(side, price);
    // A matching price joins the level, with both counters saturating.
    if (hit >= 0) begin
      if (book_orders[side][hit] != '1) book_orders[side][hit]++;
      sum = {1'b0, book_total[side][hit]} + {1'b0, qty_wide};
      book_total[side][hit] = sum[plbt_pkg::TOTAL_W] ? '1 : sum[plbt_pkg::TOTAL_W-1:0];
      r.rank  = plbt_pkg::RANK_W'(hit);
      r.count = book_orders[side][hit];
      r.total = book_total[side][hit];
      r.price = book_price[side][hit];
      return r;
    end
    // A new price on a full side is dropped with everything else zero.
    if (used >= plbt_pkg::LEVELS_PER_SIDE) begin
      r.full = 1'b1;
      return r;
    end
    // Find the first level that the new price beats, then shift the rest down.
    pos = used;
    for (int i = 0; i < used; i++)
      if (pos == used && (side == plbt_pkg::OPC_SELL ? price < book_price[side][i]
                                                     : price > book_price[side][i]))
        pos = i;
    for (int i = used; i > pos; i--) begin
      book_price[side][i]  = book_price[side][i-1];
      book_orders[side][i] = book_orders[side][i-1];
      book_total[side][i]  = book_total[side][i-1];
    end
    book_price[side][pos]  = price;
    book_orders[side][pos] = plbt_pkg::COUNT_W'(1);
    book_total[side][pos]  = qty_wide;
    book_used[side] = 32'(used + 1);
    r.rank      = plbt_pkg::RANK_W'(pos);
    r.count     = plbt_pkg::COUNT_W'(1);
    r.total     = qty_wide;
    r.price     = price;
    r.new_level = 1'b1;
    return r;
  endfunction

  // Presents one request, waits for it to be taken, and records its expected result.
  // Valid stays high afterwards so that back-to-back requests need not drop and raise it again.
  task automatic send_order(input logic side, input logic [plbt_pkg::OQTY_W-1:0] qty,
                            input logic [plbt_pkg::PRICE_W-1:0] price);
    while (idle_en && $urandom_range(99) < 11) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {price, qty};
    s_axis_tuser  <= side;
    do @(posedge clk); while (!s_axis_tready);
    level_expect_q.insert(level_expect_q.size(), apply_order(side, qty, price));
  endtask

  // Result side: random back-pressure, then compare against the oldest expectation.
  always @(posedge clk) begin
    m_axis_tready <= !idle_en || ($urandom_range(99) >= 11);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (level_expect_q.size() == 0) begin
        report_mismatch("result arrived with no request outstanding");
      end else begin
        level_want = level_expect_q.pop_front();
        level_got.rank      = m_axis_tdata[3:0];
        level_got.count     = m_axis_tdata[19:4];
        level_got.total     = m_axis_tdata[51:20];
        level_got.price     = m_axis_tdata[67:52];
        level_got.new_level = m_axis_tuser[0];
        level_got.full      = m_axis_tuser[1];
        check_field("level_rank", level_got.rank, level_want.rank);
        check_field("level_order_count", level_got.count, level_want.count);
        check_field("level_total_quantity", level_got.total, level_want.total);
        check_field("level_price", level_got.price, level_want.price);
        check_field("new_level", level_got.new_level, level_want.new_level);
        check_field("book_full", level_got.full, level_want.full);
      end
    end
  end

  // Extreme prices and quantities on both sides: inserts at the top, bottom and
  // middle, and joins at the best and the worst level.
  task automatic test_edge_orders();
    send_order(plbt_pkg::OPC_BUY, 16'h0000, 16'h0000);
    send_order(plbt_pkg::OPC_BUY, 16'hFFFF, 16'hFFFF);
    send_order(plbt_pkg::OPC_BUY, 16'h0001, 16'h8000);
    send_order(plbt_pkg::OPC_BUY, 16'hFFFF, 16'hFFFF);
    send_order(plbt_pkg::OPC_BUY, 16'h0000, 16'h0000);
    send_order(plbt_pkg::OPC_BUY, 16'hAAAA, 16'h5555);
    send_order(plbt_pkg::OPC_SELL, 16'hFFFF, 16'hFFFF);
    send_order(plbt_pkg::OPC_SELL, 16'h0000, 16'h0000);
    send_order(plbt_pkg::OPC_SELL, 16'h0007, 16'h8000);
    send_order(plbt_pkg::OPC_SELL, 16'h0000, 16'h0000);
    send_order(plbt_pkg::OPC_SELL, 16'hFFFF, 16'hFFFF);
    send_order(plbt_pkg::OPC_SELL, 16'h5555, 16'hAAAA);
    send_order(plbt_pkg::OPC_SELL, 16'hFFFF, 16'h8000);
  endtask

  // Random orders, nearly half of them aimed at a price already in the book.
  task automatic test_random_orders(input int count);
    logic                         side;
    logic [plbt_pkg::OQTY_W-1:0]  qty;
    logic [plbt_pkg::PRICE_W-1:0] price;
    int                           pick;
    for (int n = 0; n < count; n++) begin
      side = 1'($urandom_range(1));
      pick = int'($urandom_range(99));
      if (pick < 45 && book_used[side] > 0)
        price = book_price[side][$urandom_range(book_used[side] - 1)];
      else if (pick < 55)
        price = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      else
        price = plbt_pkg::PRICE_W'($urandom);
      pick = int'($urandom_range(99));
      if (pick < 10) qty = '0;
      else if (pick < 20) qty = '1;
      else qty = plbt_pkg::OQTY_W'($urandom);
      send_order(side, qty, price);
    end
  endtask

  // Fills each side to capacity, then offers new prices that must be dropped
  // and a known price that must still be absorbed.
  task automatic test_full_table();
    logic [plbt_pkg::PRICE_W-1:0] price;
    for (int s = 0; s < 2; s++) begin
      while (book_used[s] < plbt_pkg::LEVELS_PER_SIDE) begin
        do price = plbt_pkg::PRICE_W'($urandom); while (level_of(1'(s), price) >= 0);
        send_order(1'(s), plbt_pkg::OQTY_W'($urandom), price);
      end
      for (int k = 0; k < 3; k++) begin
        do price = plbt_pkg::PRICE_W'($urandom); while (level_of(1'(s), price) >= 0);
        send_order(1'(s), plbt_pkg::OQTY_W'($urandom), price);
      end
      send_order(1'(s), plbt_pkg::OQTY_W'($urandom),
                 book_price[s][$urandom_range(plbt_pkg::LEVELS_PER_SIDE - 1)]);
    end
  endtask

  // Repeated large orders joining one level, as the long stretch without idling
  // on either side.
  task automatic test_repeated_joins();
    logic [plbt_pkg::PRICE_W-1:0] price;
    idle_en = 1'b0;
    price = book_price[plbt_pkg::OPC_BUY][plbt_pkg::LEVELS_PER_SIDE / 2];
    for (int n = 0; n < JOIN_ORDERS; n++)
      send_order(plbt_pkg::OPC_BUY, 16'hFFFF, price);
    idle_en = 1'b1;
  endtask

  // Test sequence: reset once, run each test, drain, then give the verdict.
  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_edge_orders();
    test_random_orders(420);
    test_full_table();
    test_repeated_joins();
    test_random_orders(40);
    s_axis_tvalid <= 1'b0;
    while (level_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[order_book_price_level_table] OK");
    end else begin
      $display("[order_book_price_level_table] ERROR");
    end
    $finish;
  end

endmodule
